// File: hw/rtl/asc_pkg.sv
// shared types, microcode table and field constants for the aliquot sum classifier
`default_nettype none

package asc_pkg;

  // result field widths
  localparam int COUNT_W = 8;
  localparam int SUM_W   = 22;

  // microprogram addresses
  typedef logic [2:0] upc_t;

  localparam upc_t UPC_IDLE  = 3'd0;
  localparam upc_t UPC_TEST  = 3'd1;
  localparam upc_t UPC_DIV   = 3'd2;
  localparam upc_t UPC_ADD_D = 3'd3;
  localparam upc_t UPC_ADD_Q = 3'd4;
  localparam upc_t UPC_PASS  = 3'd5;
  localparam upc_t UPC_OUT   = 3'd6;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_SQ_GT,
    C_DIV_RUN,
    C_CHAIN
  } cond_t;

  // datapath micro-operations
  typedef struct packed {
    logic busy;
    logic init;
    logic div_load;
    logic div_step;
    logic add_d;
    logic add_q;
    logic end_pass;
    logic emit;
  } uops_t;

  // one control word
  typedef struct packed {
    cond_t cond;
    upc_t  target;
    uops_t ops;
  } uword_t;

  // status flags fed back to the sequencer
  typedef struct packed {
    logic start;
    logic sq_gt;
    logic div_run;
    logic chain;
  } ustat_t;

  // the microprogram
  function automatic uword_t urom(upc_t addr);
    uword_t w;
    w        = '0;
    w.cond   = C_NEVER;
    w.target = UPC_IDLE;
    case (addr)
      UPC_IDLE: begin
        w.cond     = C_IDLE;
        w.target   = UPC_IDLE;
        w.ops.init = 1'b1;
      end
      UPC_TEST: begin
        w.cond         = C_SQ_GT;
        w.target       = UPC_PASS;
        w.ops.busy     = 1'b1;
        w.ops.div_load = 1'b1;
      end
      UPC_DIV: begin
        w.cond         = C_DIV_RUN;
        w.target       = UPC_DIV;
        w.ops.busy     = 1'b1;
        w.ops.div_step = 1'b1;
      end
      UPC_ADD_D: begin
        w.cond      = C_NEVER;
        w.ops.busy  = 1'b1;
        w.ops.add_d = 1'b1;
      end
      UPC_ADD_Q: begin
        w.cond      = C_ALWAYS;
        w.target    = UPC_TEST;
        w.ops.busy  = 1'b1;
        w.ops.add_q = 1'b1;
      end
      UPC_PASS: begin
        w.cond         = C_CHAIN;
        w.target       = UPC_TEST;
        w.ops.busy     = 1'b1;
        w.ops.end_pass = 1'b1;
      end
      UPC_OUT: begin
        w.cond     = C_ALWAYS;
        w.target   = UPC_IDLE;
        w.ops.busy = 1'b1;
        w.ops.emit = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aliquot_sum_classifier.sv
// top level: aliquot sum datapath driven by the microcode sequencer
// a second pass runs over the divisor sum s when s exceeds n; each
// trial divisor takes a test step, the shared divider at one bit per
// cycle, and two add steps.
// one transaction at a time: busy stays high until the result strobe.
// synchronous reset returns the sequencer to idle; done is strobed one cycle.
`default_nettype none

module aliquot_sum_classifier
  import asc_pkg::*;
#(
  parameter int NUM_BITS = 20
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire  [NUM_BITS-1:0] number,
  output logic                done,
  output logic [COUNT_W-1:0]  divisor_count,
  output logic [SUM_W-1:0]    divisor_sum,
  output logic                is_perfect,
  output logic                is_amicable,
  output logic [SUM_W-1:0]    partner,
  output logic                overflow
);

  // working widths: sums, trial divisor, divisor count
  localparam int SW  = NUM_BITS + 6;
  localparam int DW  = (SW + 1) / 2 + 1;
  localparam int CW  = NUM_BITS / 2 + 3;
  localparam int SXW = (SW > SUM_W) ? SW : SUM_W;
  localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

  uops_t  ops;
  ustat_t stat;

  logic [NUM_BITS-1:0] n_r;
  logic [SW-1:0]       m;
  logic [DW-1:0]       d;
  logic [SW:0]         sq;
  logic [SW-1:0]       sum;
  logic [CW-1:0]       cnt;
  logic                pass;
  logic [SW-1:0]       s1;
  logic [CW-1:0]       cnt1;
  logic                amic;

  logic [SW-1:0]  q;
  logic [DW-1:0]  rem;
  logic           div_last;
  logic           rem_zero;
  logic           q_new;
  logic [SW-1:0]  nx;
  logic [SXW-1:0] s1x;
  logic [CXW-1:0] cnt1x;
  logic           sum_ovf;
  logic           cnt_ovf;

  asc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ops  (ops)
  );

  asc_div #(
    .NW (SW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .load      (ops.div_load),
    .step      (ops.div_step),
    .dividend  (m),
    .divisor   (d),
    .quotient  (q),
    .remainder (rem),
    .last      (div_last)
  );

  assign busy = ops.busy;
  assign nx   = SW'(n_r);

  // divisor tests
  assign rem_zero = rem == '0;
  assign q_new    = (q != m) && (q != SW'(d));

  // status back to the sequencer
  assign stat.start   = start;
  assign stat.sq_gt   = sq > {1'b0, m};
  assign stat.div_run = ~div_last;
  assign stat.chain   = ~pass && (n_r > NUM_BITS'(1)) && (sum > nx);

  // saturation of the first-pass results
  assign s1x     = SXW'(s1);
  assign cnt1x   = CXW'(cnt1);
  assign sum_ovf = s1x > SXW'({SUM_W{1'b1}});
  assign cnt_ovf = cnt1x > CXW'({COUNT_W{1'b1}});

  // working registers
  always_ff @(posedge clk) begin
    if (ops.init) begin
      n_r  <= number;
      m    <= SW'(number);
      d    <= DW'(1);
      sq   <= (SW + 1)'(1);
      sum  <= '0;
      cnt  <= '0;
      pass <= 1'b0;
      amic <= 1'b0;
    end
    if (ops.add_d && rem_zero) begin
      sum <= sum + SW'(d);
      cnt <= cnt + CW'(1);
    end
    if (ops.add_q) begin
      if (rem_zero && q_new) begin
        sum <= sum + q;
        cnt <= cnt + CW'(1);
      end
      d  <= d + DW'(1);
      sq <= sq + (SW + 1)'({d, 1'b1});
    end
    if (ops.end_pass) begin
      if (!pass) begin
        s1   <= sum;
        cnt1 <= cnt;
        if (stat.chain) begin
          m    <= sum;
          d    <= DW'(1);
          sq   <= (SW + 1)'(1);
          sum  <= '0;
          cnt  <= '0;
          pass <= 1'b1;
        end
      end else begin
        amic <= sum == nx;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ops.emit) begin
      divisor_count <= cnt_ovf ? {COUNT_W{1'b1}} : cnt1x[COUNT_W-1:0];
      divisor_sum   <= sum_ovf ? {SUM_W{1'b1}} : s1x[SUM_W-1:0];
      is_perfect    <= (s1 == nx) && (n_r > NUM_BITS'(1));
      is_amicable   <= amic;
      partner       <= !amic ? '0 : (sum_ovf ? {SUM_W{1'b1}} : s1x[SUM_W-1:0]);
      overflow      <= sum_ovf || cnt_ovf;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ops.emit;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/asc_seq.sv
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module asc_seq
  import asc_pkg::*;
(
  input  wire    clk,
  input  wire    rst,
  input  ustat_t stat,
  output uops_t  ops
);

  upc_t   upc;
  upc_t   upc_next;
  uword_t word;
  logic   take;

  // control store read
  assign word = urom(upc);
  assign ops  = word.ops;

  // jump condition select
  always_comb begin
    case (word.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_IDLE:    take = ~stat.start;
      C_SQ_GT:   take = stat.sq_gt;
      C_DIV_RUN: take = stat.div_run;
      C_CHAIN:   take = stat.chain;
      default:   take = 1'b1;
    endcase
    upc_next = take ? word.target : upc + 3'd1;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/asc_div.sv
// restoring divider, one quotient bit per cycle while step is asserted
`default_nettype none

module asc_div #(
  parameter int NW = 26,
  parameter int DW = 14
) (
  input  wire           clk,
  input  wire           load,
  input  wire           step,
  input  wire  [NW-1:0] dividend,
  input  wire  [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic          last
);

  localparam int KW = $clog2(NW + 1);

  logic [KW-1:0] cnt;
  logic [DW:0]   trial;
  logic          fits;

  // trial subtract of the next partial remainder
  assign trial = {remainder, quotient[NW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign last  = cnt == KW'(1);

  // shift and subtract
  always_ff @(posedge clk) begin
    if (load) begin
      quotient  <= dividend;
      remainder <= '0;
      cnt       <= KW'(NW);
    end else if (step) begin
      remainder <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      quotient  <= {quotient[NW-2:0], fits};
      cnt       <= cnt - KW'(1);
    end
  end

endmodule

`default_nettype wire
